/* rtl/differential_drive_odometry_assert.svh */
// Assertion macros shared by the checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DDO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication that is also checked through reset
`define DDO_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/ddo_pkg.sv */
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd197;
    localparam logic [15:0] WHEEL_RADIUS_RST  = 16'd1507;
    localparam logic [15:0] INV_TRACK_RST     = 16'd1280;

    // register indexes on the config port
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_WHEEL_RADIUS  = 2'd1;
    localparam logic [1:0] REG_INV_TRACK     = 2'd2;

    // 2^30/pi split into high and low 15-bit halves
    localparam logic signed [17:0] RAD2BAM_HI = 18'sd10430;
    localparam logic signed [17:0] RAD2BAM_LO = 18'sd12398;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_M9, S_M10, S_M11, S_CORD, S_CS, S_DX, S_DY, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_SR, MUL_DR, MUL_SRIB, MUL_SRDT, MUL_DRDT,
        MUL_EIB, MUL_PH, MUL_PL, MUL_DX, MUL_DY
    } t_mul_sel;

    typedef enum logic [3:0] {
        CAP_NONE, CAP_SR, CAP_DR, CAP_W, CAP_DS, CAP_E, CAP_DRAD,
        CAP_PH, CAP_PL, CAP_CS, CAP_DX, CAP_DY
    } t_cap_sel;

    typedef struct packed {
        logic              load_in;
        t_mul_sel          mul_sel;
        t_cap_sel          cap_sel;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [15:0] sat16(input logic signed [59:0] v);
        if (v > 60'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -60'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // atan(2^-i) with 2^32 = 2 pi
    function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
        case (idx)
            5'd0:  return 34'sd536870912;
            5'd1:  return 34'sd316933406;
            5'd2:  return 34'sd167458907;
            5'd3:  return 34'sd85004756;
            5'd4:  return 34'sd42667331;
            5'd5:  return 34'sd21354465;
            5'd6:  return 34'sd10679838;
            5'd7:  return 34'sd5340245;
            5'd8:  return 34'sd2670163;
            5'd9:  return 34'sd1335087;
            5'd10: return 34'sd667544;
            5'd11: return 34'sd333772;
            5'd12: return 34'sd166886;
            5'd13: return 34'sd83443;
            5'd14: return 34'sd41722;
            5'd15: return 34'sd20861;
            5'd16: return 34'sd10430;
            5'd17: return 34'sd5215;
            5'd18: return 34'sd2608;
            5'd19: return 34'sd1304;
            5'd20: return 34'sd652;
            5'd21: return 34'sd326;
            5'd22: return 34'sd163;
            5'd23: return 34'sd81;
            default: return 34'sd0;
        endcase
    endfunction

endpackage

/* rtl/ddo_if.sv */
// Wheel speed sample channel
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_wheel_speed;
    logic signed [15:0] left_wheel_speed;
    modport source(output valid, right_wheel_speed, left_wheel_speed, input ready);
    modport sink(input valid, right_wheel_speed, left_wheel_speed, output ready);
endinterface

// Pose result channel
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic signed [15:0] heading_angle;
    logic signed [15:0] turn_rate;
    logic signed [15:0] forward_speed;
    modport source(output valid, x_position, y_position, heading_angle, turn_rate,
                   forward_speed, input ready);
    modport sink(input valid, x_position, y_position, heading_angle, turn_rate,
                 forward_speed, output ready);
endinterface

/* rtl/ddo_ctrl.sv */
module ddo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ddo_pkg::t_status i_status,
    output logic            o_in_ready,
    output ddo_pkg::t_cmd   o_cmd
);
    import ddo_pkg::*;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              iter_last;

    assign iter_last = (r_iter == ITER_W'(CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_M6;
            S_M6:    n_state = S_M7;
            S_M7:    n_state = S_M8;
            S_M8:    n_state = S_M9;
            S_M9:    n_state = S_M10;
            S_M10:   n_state = S_M11;
            S_M11:   n_state = S_CORD;
            S_CORD:  if (iter_last) n_state = S_CS;
            S_CS:    n_state = S_DX;
            S_DX:    n_state = S_DY;
            S_DY:    n_state = S_FIN;
            S_FIN:   if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // CORDIC iteration counter
    always_comb begin
        n_iter = r_iter;
        if (r_state == S_M11) begin
            n_iter = '0;
        end else if (r_state == S_CORD && !iter_last) begin
            n_iter = r_iter + 1'b1;
        end
    end

    // commands to the datapath
    always_comb begin
        o_in_ready          = 1'b0;
        o_cmd.load_in       = 1'b0;
        o_cmd.mul_sel       = MUL_NONE;
        o_cmd.cap_sel       = CAP_NONE;
        o_cmd.cordic_step   = 1'b0;
        o_cmd.iter          = r_iter;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_M1:  o_cmd.mul_sel = MUL_SR;
            S_M2: begin
                o_cmd.mul_sel = MUL_DR;
                o_cmd.cap_sel = CAP_SR;
            end
            S_M3: begin
                o_cmd.mul_sel = MUL_SRIB;
                o_cmd.cap_sel = CAP_DR;
            end
            S_M4: begin
                o_cmd.mul_sel = MUL_SRDT;
                o_cmd.cap_sel = CAP_W;
            end
            S_M5: begin
                o_cmd.mul_sel = MUL_DRDT;
                o_cmd.cap_sel = CAP_DS;
            end
            S_M6:  o_cmd.cap_sel = CAP_E;
            S_M7:  o_cmd.mul_sel = MUL_EIB;
            S_M8:  o_cmd.cap_sel = CAP_DRAD;
            S_M9:  o_cmd.mul_sel = MUL_PH;
            S_M10: begin
                o_cmd.mul_sel = MUL_PL;
                o_cmd.cap_sel = CAP_PH;
            end
            S_M11: o_cmd.cap_sel = CAP_PL;
            S_CORD: o_cmd.cordic_step = 1'b1;
            S_CS:  o_cmd.cap_sel = CAP_CS;
            S_DX:  o_cmd.mul_sel = MUL_DX;
            S_DY: begin
                o_cmd.mul_sel = MUL_DY;
                o_cmd.cap_sel = CAP_DX;
            end
            S_FIN: if (i_status.out_free) o_cmd.cap_sel = CAP_DY;
            default: ;
        endcase
    end

endmodule

/* rtl/ddo_datapath.sv */
module ddo_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_cmd       i_cmd,
    input  logic signed [15:0]  i_right_wheel_speed,
    input  logic signed [15:0]  i_left_wheel_speed,
    input  logic [15:0]         i_sample_period,
    input  logic [15:0]         i_wheel_radius,
    input  logic [15:0]         i_inverse_track_width,
    input  logic                i_out_ready,
    output ddo_pkg::t_status    o_status,
    output logic                o_out_valid,
    output logic signed [31:0]  o_x_position,
    output logic signed [31:0]  o_y_position,
    output logic signed [15:0]  o_heading_angle,
    output logic signed [15:0]  o_turn_rate,
    output logic signed [15:0]  o_forward_speed
);
    import ddo_pkg::*;

    logic signed [16:0] r_sum, r_diff;
    logic signed [33:0] r_msr, r_mdr;
    logic signed [41:0] r_ds;
    logic signed [34:0] r_e;
    logic signed [35:0] r_drad;
    logic [47:0]        r_ph;
    logic [15:0]        r_dth;
    logic signed [15:0] r_v, r_w;
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic signed [17:0] r_c, r_s;
    logic signed [31:0] r_dx;
    logic signed [59:0] r_prod;
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [15:0]        r_heading;
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic [15:0]        r_out_h;
    logic signed [15:0] r_out_w, r_out_v;

    logic signed [41:0] mul_a;
    logic signed [17:0] mul_b;
    logic [47:0]        p_sum, p_rnd_d, p_rnd_h;
    logic [15:0]        mid;
    logic               mid_flip;
    logic [31:0]        z_start;
    logic signed [33:0] xs, ys, atan_v;
    logic signed [18:0] cx, sy;
    logic signed [31:0] dy;
    logic signed [31:0] n_pos_x, n_pos_y;
    logic [15:0]        n_heading;
    logic               commit;

    assign commit            = (i_cmd.cap_sel == CAP_DY);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_SR: begin
                mul_a = 42'(r_sum);
                mul_b = $signed({2'b00, i_wheel_radius});
            end
            MUL_DR: begin
                mul_a = 42'(r_diff);
                mul_b = $signed({2'b00, i_wheel_radius});
            end
            MUL_SRIB: begin
                // diff * radius is still on the multiplier output
                mul_a = 42'(r_prod);
                mul_b = $signed({2'b00, i_inverse_track_width});
            end
            MUL_SRDT: begin
                mul_a = 42'(r_msr);
                mul_b = $signed({2'b00, i_sample_period});
            end
            MUL_DRDT: begin
                mul_a = 42'(r_mdr);
                mul_b = $signed({2'b00, i_sample_period});
            end
            MUL_EIB: begin
                mul_a = 42'(r_e);
                mul_b = $signed({2'b00, i_inverse_track_width});
            end
            MUL_PH: begin
                mul_a = 42'(r_drad);
                mul_b = RAD2BAM_HI;
            end
            MUL_PL: begin
                mul_a = 42'(r_drad);
                mul_b = RAD2BAM_LO;
            end
            MUL_DX: begin
                mul_a = r_ds;
                mul_b = r_c;
            end
            MUL_DY: begin
                mul_a = r_ds;
                mul_b = r_s;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // radians to binary angle, midpoint heading and CORDIC start angle
    assign p_sum    = 48'(r_ph << 15) + r_prod[47:0];
    assign p_rnd_d  = p_sum + 48'h0000_4000_0000;
    assign p_rnd_h  = p_sum + 48'h0000_8000_0000;
    assign mid      = r_heading + p_rnd_h[47:32];
    assign mid_flip = 1'((mid + 16'h4000) >> 15);
    assign z_start  = {mid ^ {mid_flip, 15'd0}, 16'd0};

    // CORDIC micro-rotation
    assign xs     = r_x >>> i_cmd.iter;
    assign ys     = r_y >>> i_cmd.iter;
    assign atan_v = atan_lut(5'(i_cmd.iter));

    // rounded sin and cos
    assign cx = 19'((r_x + 34'sd16384) >>> 15);
    assign sy = 19'((r_y + 34'sd16384) >>> 15);

    // pose update
    assign dy        = 32'((r_prod + 60'sd1073741824) >>> 31);
    assign n_pos_x   = r_pos_x + r_dx;
    assign n_pos_y   = r_pos_y + dy;
    assign n_heading = r_heading + r_dth;

    // intermediate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sum  <= 17'(i_right_wheel_speed) + 17'(i_left_wheel_speed);
            r_diff <= 17'(i_right_wheel_speed) - 17'(i_left_wheel_speed);
        end
        case (i_cmd.cap_sel)
            CAP_SR: begin
                r_msr <= r_prod[33:0];
                r_v   <= sat16((r_prod + 60'sd65536) >>> 17);
            end
            CAP_DR:   r_mdr  <= r_prod[33:0];
            CAP_W:    r_w    <= sat16((r_prod + 60'sd8388608) >>> 24);
            CAP_DS:   r_ds   <= 42'((r_prod + 60'sd256) >>> 9);
            CAP_E:    r_e    <= 35'((r_prod + 60'sd32768) >>> 16);
            CAP_DRAD: r_drad <= 36'((r_prod + 60'sd32768) >>> 16);
            CAP_PH:   r_ph   <= r_prod[47:0];
            CAP_PL: begin
                r_dth  <= p_rnd_d[46:31];
                r_flip <= mid_flip;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= 34'($signed(z_start));
            end
            CAP_CS: begin
                r_c <= r_flip ? 18'(-cx) : 18'(cx);
                r_s <= r_flip ? 18'(-sy) : 18'(sy);
            end
            CAP_DX:   r_dx <= 32'((r_prod + 60'sd1073741824) >>> 31);
            default: ;
        endcase
        if (i_cmd.cordic_step) begin
            if (!r_z[33]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end
        end
        if (commit) begin
            r_out_x <= n_pos_x;
            r_out_y <= n_pos_y;
            r_out_h <= n_heading;
            r_out_w <= r_w;
            r_out_v <= r_v;
        end
    end

    // pose state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_heading <= n_heading;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_x_position    = r_out_x;
    assign o_y_position    = r_out_y;
    assign o_heading_angle = r_out_h;
    assign o_turn_rate     = r_out_w;
    assign o_forward_speed = r_out_v;

endmodule

/* rtl/differential_drive_odometry.sv */
// A sample passes through 11 multiplier steps on one shared 42x18 multiplier,
//   CORDIC_STEPS CORDIC iterations and 4 finishing steps before the pose is valid.
// A sample is taken only once the last one is through, at a rate set by the shared
//   multiplier and CORDIC loop. The last step stalls while the output register is full.
// The next sample is taken while the previous pose still waits in the output register.
// Reset (synchronous, active low): pose and heading clear, registers load their defaults.
module differential_drive_odometry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddo_in_if.sink      i_odo_in,
    ddo_out_if.source   o_odo_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ddo_pkg::*;

    logic [15:0] r_sample_period, r_wheel_radius, r_inv_track;
    logic [1:0]  reg_idx;
    t_cmd        cmd;
    t_status     status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RST;
            r_wheel_radius  <= WHEEL_RADIUS_RST;
            r_inv_track     <= INV_TRACK_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_SAMPLE_PERIOD: r_sample_period <= pwdata[15:0];
                REG_WHEEL_RADIUS:  r_wheel_radius  <= pwdata[15:0];
                REG_INV_TRACK:     r_inv_track     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_SAMPLE_PERIOD: prdata = {16'd0, r_sample_period};
            REG_WHEEL_RADIUS:  prdata = {16'd0, r_wheel_radius};
            REG_INV_TRACK:     prdata = {16'd0, r_inv_track};
            default:           prdata = '0;
        endcase
    end

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_odo_in.valid),
        .i_status   (status),
        .o_in_ready (i_odo_in.ready),
        .o_cmd      (cmd)
    );

    ddo_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_right_wheel_speed   (i_odo_in.right_wheel_speed),
        .i_left_wheel_speed    (i_odo_in.left_wheel_speed),
        .i_sample_period       (r_sample_period),
        .i_wheel_radius        (r_wheel_radius),
        .i_inverse_track_width (r_inv_track),
        .i_out_ready           (o_odo_out.ready),
        .o_status              (status),
        .o_out_valid           (o_odo_out.valid),
        .o_x_position          (o_odo_out.x_position),
        .o_y_position          (o_odo_out.y_position),
        .o_heading_angle       (o_odo_out.heading_angle),
        .o_turn_rate           (o_odo_out.turn_rate),
        .o_forward_speed       (o_odo_out.forward_speed)
    );

endmodule

/* rtl/ddo_checker.sv */
`include "differential_drive_odometry_assert.svh"

module ddo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x
);

    // no result right after reset
    `DDO_ASSERT_ALWAYS(a_rst_quiet, $past(!i_rst_n), !i_out_valid, "result valid after reset")
    // a sample keeps the block busy, so the input closes right after an accept
    `DDO_ASSERT_NEXT(a_busy, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")
    // a result never appears in the cycle after an accept
    `DDO_ASSERT_NOW(a_latency, $rose(i_out_valid), !$past(i_in_valid && i_in_ready),
                    "result too early")
    // a stalled result holds
    `DDO_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_x),
                     "stalled result changed")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_odo_in.valid),
    .i_in_ready  (i_odo_in.ready),
    .i_out_valid (o_odo_out.valid),
    .i_out_ready (o_odo_out.ready),
    .i_out_x     (o_odo_out.x_position)
);
